FILE: hdl/olec_pkg.sv
package olec_pkg;

  // default node store size
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int KEY_W       = 32;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_ANCHOR = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_KEY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  // anchor value that selects the list front
  localparam logic signed [KEY_W-1:0] ANCHOR_FRONT = -32'sd1;

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_LINK,
    S_UNLINK,
    S_DONE
  } olec_state_t;

  // store access strobes
  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic link_we;
  } store_cmd_t;

endpackage

FILE: hdl/olec_store.sv
module olec_store #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int IW       = 7
) (
  input  logic                       clk,
  input  olec_pkg::store_cmd_t       cmd,
  input  logic [AW-1:0]              rd_addr,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [olec_pkg::KEY_W-1:0] wr_key,
  input  logic [IW-1:0]              wr_link,
  output logic signed [olec_pkg::KEY_W-1:0] rd_key,
  output logic [IW-1:0]              rd_link
);
  import olec_pkg::*;

  logic signed [KEY_W-1:0] key_mem  [CAPACITY];
  logic [IW-1:0]           link_mem [CAPACITY];

  // key memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (cmd.rd_en) begin
      rd_key <= key_mem[rd_addr];
    end
  end

  // link memory, same address as the key read
  always_ff @(posedge clk) begin
    if (cmd.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (cmd.rd_en) begin
      rd_link <= link_mem[rd_addr];
    end
  end

endmodule

FILE: hdl/olec_ctrl.sv
module olec_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int IW       = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  // request side
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olec_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic signed [olec_pkg::KEY_W-1:0]   in_key,
  input  logic signed [olec_pkg::KEY_W-1:0]   in_anchor,
  // result side
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [olec_pkg::STATUS_W-1:0]       res_status,
  output logic                                res_front,
  output logic signed [olec_pkg::KEY_W-1:0]   res_prev_key,
  // node store port
  output olec_pkg::store_cmd_t                cmd,
  output logic [AW-1:0]                       rd_addr,
  output logic [AW-1:0]                       wr_addr,
  output logic signed [olec_pkg::KEY_W-1:0]   wr_key,
  output logic [IW-1:0]                       wr_link,
  input  logic signed [olec_pkg::KEY_W-1:0]   rd_key,
  input  logic [IW-1:0]                       rd_link
);
  import olec_pkg::*;

  localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  olec_state_t state, state_next;

  // list header and counters
  logic [IW-1:0] init_idx;
  logic [IW-1:0] first_node;
  logic [IW-1:0] free_head;
  logic [IW-1:0] used_count;

  // request held for the walk
  logic [OPCODE_W-1:0]     op_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] anchor_q;
  logic                    at_front;

  // walk position and saved links
  logic [IW-1:0]           cur;
  logic [IW-1:0]           prev_idx;
  logic signed [KEY_W-1:0] prev_key;
  logic [IW-1:0]           nx;
  logic [IW-1:0]           nn;

  logic                    in_fire;
  logic                    in_front;
  logic                    in_walk;
  logic                    store_full;
  logic                    hit_now;
  logic                    link_null;
  logic signed [KEY_W-1:0] target;

  // decode
  assign in_fire    = in_valid && in_ready;
  assign in_front   = (in_opcode == OP_INSERT) && (in_anchor == ANCHOR_FRONT);
  assign in_walk    = (in_opcode == OP_INSERT) ? !in_front :
                      ((in_opcode == OP_DELETE) || (in_opcode == OP_FIND));
  assign store_full = (free_head == NULL_IDX) || (used_count >= NULL_IDX);
  assign target     = (op_q == OP_INSERT) ? anchor_q : key_q;
  assign hit_now    = (rd_key == target);
  assign link_null  = (rd_link == NULL_IDX);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_idx == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_walk) begin
            state_next = (first_node == NULL_IDX) ? S_DONE : S_WALK;
          end else if (in_front && !store_full) begin
            state_next = S_ALLOC;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (hit_now) begin
          case (op_q)
            OP_INSERT: state_next = store_full ? S_DONE : S_ALLOC;
            OP_DELETE: state_next = (prev_idx == NULL_IDX) ? S_DONE : S_UNLINK;
            default:   state_next = S_DONE;
          endcase
        end else if (link_null) begin
          state_next = S_DONE;
        end
      end
      S_ALLOC:  state_next = at_front ? S_DONE : S_LINK;
      S_LINK:   state_next = S_DONE;
      S_UNLINK: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default:  state_next = S_INIT;
    endcase
  end

  // store accesses and handshakes
  always_comb begin
    cmd       = '0;
    rd_addr   = '0;
    wr_addr   = '0;
    wr_key    = key_q;
    wr_link   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state)
      S_INIT: begin
        cmd.link_we = 1'b1;
        wr_addr     = init_idx[AW-1:0];
        wr_link     = init_idx + IW'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_walk && (first_node != NULL_IDX)) begin
            cmd.rd_en = 1'b1;
            rd_addr   = first_node[AW-1:0];
          end else if (in_front && !store_full) begin
            cmd.rd_en = 1'b1;
            rd_addr   = free_head[AW-1:0];
          end
        end
      end
      S_WALK: begin
        if (hit_now) begin
          if ((op_q == OP_INSERT) && !store_full) begin
            cmd.rd_en = 1'b1;
            rd_addr   = free_head[AW-1:0];
          end else if (op_q == OP_DELETE) begin
            // freed node goes to the head of the free chain
            cmd.link_we = 1'b1;
            wr_addr     = cur[AW-1:0];
            wr_link     = free_head;
          end
        end else if (!link_null) begin
          cmd.rd_en = 1'b1;
          rd_addr   = rd_link[AW-1:0];
        end
      end
      S_ALLOC: begin
        cmd.key_we  = 1'b1;
        cmd.link_we = 1'b1;
        wr_addr     = free_head[AW-1:0];
        wr_link     = at_front ? first_node : nx;
      end
      S_LINK: begin
        cmd.link_we = 1'b1;
        wr_addr     = cur[AW-1:0];
        wr_link     = nn;
      end
      S_UNLINK: begin
        cmd.link_we = 1'b1;
        wr_addr     = prev_idx[AW-1:0];
        wr_link     = nx;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      first_node <= NULL_IDX;
      free_head  <= '0;
      used_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT: begin
          init_idx <= init_idx + IW'(1);
        end
        S_IDLE: begin
          if (in_fire) begin
            op_q         <= in_opcode;
            key_q        <= in_key;
            anchor_q     <= in_anchor;
            at_front     <= in_front;
            cur          <= first_node;
            prev_idx     <= NULL_IDX;
            prev_key     <= '0;
            res_front    <= 1'b0;
            res_prev_key <= '0;
            if (in_walk && (first_node == NULL_IDX)) begin
              res_status <= (in_opcode == OP_INSERT) ? STAT_NO_ANCHOR : STAT_NO_KEY;
            end else if (in_front && store_full) begin
              res_status <= STAT_FULL;
            end else begin
              res_status <= STAT_OK;
            end
          end
        end
        S_WALK: begin
          if (hit_now) begin
            nx <= rd_link;
            case (op_q)
              OP_INSERT: begin
                if (store_full) res_status <= STAT_FULL;
              end
              OP_DELETE: begin
                free_head <= cur;
                if (used_count != '0) used_count <= used_count - IW'(1);
                if (prev_idx == NULL_IDX) first_node <= rd_link;
              end
              default: begin
                if (prev_idx == NULL_IDX) res_front <= 1'b1;
                else res_prev_key <= prev_key;
              end
            endcase
          end else if (link_null) begin
            res_status <= (op_q == OP_INSERT) ? STAT_NO_ANCHOR : STAT_NO_KEY;
          end else begin
            prev_idx <= cur;
            prev_key <= rd_key;
            cur      <= rd_link;
          end
        end
        S_ALLOC: begin
          nn         <= free_head;
          free_head  <= rd_link;
          used_count <= used_count + IW'(1);
          if (at_front) first_node <= free_head;
        end
        default: begin
          init_idx <= init_idx;
        end
      endcase
    end
  end

endmodule

FILE: hdl/ordered_list_engine_core.sv
// channel   dir  signals                    payload
// request   in   s_tvalid s_tready s_tdata  opcode, key, anchor_key
// result    out  m_tvalid m_tready m_tdata  status, prev_is_front, prev_key
//
// one request at a time; insert at the front needs no walk, a walking
// request reads its nodes one per cycle through the node store read port.
// after rst the link memory is chained as free, with s_tready low. a new
// request is taken while a result waits in the output register; a stalled
// result holds the sequencer only at its next finish.
module ordered_list_engine_core #(
  parameter int CAPACITY = olec_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [1:0] opcode, [33:2] key, [65:34] anchor_key, [71:66] zero
  input  logic [olec_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [1:0] status, [2] prev_is_front, [34:3] prev_key, [39:35] zero
  output logic [olec_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import olec_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = $clog2(CAPACITY + 1);

  store_cmd_t              cmd;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_key;
  logic [IW-1:0]           wr_link;
  logic signed [KEY_W-1:0] rd_key;
  logic [IW-1:0]           rd_link;

  logic                    res_valid;
  logic                    res_ready;
  logic [STATUS_W-1:0]     res_status;
  logic                    res_front;
  logic signed [KEY_W-1:0] res_prev_key;

  logic [STATUS_W-1:0]     status;
  logic                    prev_is_front;
  logic signed [KEY_W-1:0] prev_key;

  olec_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .IW       (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_opcode    (s_tdata[1:0]),
    .in_key       (s_tdata[33:2]),
    .in_anchor    (s_tdata[65:34]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_status   (res_status),
    .res_front    (res_front),
    .res_prev_key (res_prev_key),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_key       (wr_key),
    .wr_link      (wr_link),
    .rd_key       (rd_key),
    .rd_link      (rd_link)
  );

  olec_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .IW       (IW)
  ) u_store (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_link (wr_link),
    .rd_key  (rd_key),
    .rd_link (rd_link)
  );

  // output register, loaded when empty or being drained
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status        <= res_status;
      prev_is_front <= res_front;
      prev_key      <= res_prev_key;
    end
  end

  assign m_tdata = {5'b0, prev_key, prev_is_front, status};

endmodule
